// ===== rtl/core/segment_tree_point_update_range_sum_defines.svh =====
// Assertion macros for the segment tree range-sum block
`ifndef SEGMENT_TREE_POINT_UPDATE_RANGE_SUM_DEFINES_SVH
`define SEGMENT_TREE_POINT_UPDATE_RANGE_SUM_DEFINES_SVH

// clocked property, off during reset
`define SEG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication, off during reset
`define SEG_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) else $error(msg);

`endif

// ===== rtl/core/seg_pkg.sv =====
// Shared types and codes for the segment tree range-sum block
package seg_pkg;

  localparam int unsigned ValW = 64;

  typedef logic [ValW-1:0] seg_val_t;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_SET   = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NONE  = 2'd3
  } seg_cmd_e;

  typedef struct packed {
    logic is_query;
    logic is_add;
    logic live;
  } seg_ctl_t;

endpackage

// ===== rtl/core/segment_tree_point_update_range_sum.sv =====
// Segment tree range-sum block: command intake, level chain, result output
// One item in the level chain; a result held on the output does not block the next item,
// a second result holds the chain until the output frees.
// Reset: rst_ni low clears control; a zeroing pass then clears every level store,
// and no item is accepted during it.
module segment_tree_point_update_range_sum #(
  parameter int unsigned LEAVES = 1024
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // element_index[9:0], update_value[73:10], range_first[83:74], range_last[93:84]
  input  logic [95:0]  s_axis_tdata,
  // command[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // range_sum[63:0]
  output logic [63:0]  m_axis_tdata
);
  import seg_pkg::*;
  `include "segment_tree_point_update_range_sum_defines.svh"

  localparam int unsigned LOG = $clog2(LEAVES);
  localparam int unsigned IW  = LOG + 1;

  logic          vld [LOG+2];
  seg_ctl_t      ctl [LOG+2];
  logic [IW-1:0] lo  [LOG+2];
  logic [IW-1:0] hi  [LOG+2];
  seg_val_t      acc [LOG+2];

  logic          clr_q, busy_q, res_pend_q, out_vld_q;
  logic [IW-1:0] clr_cnt_q;
  seg_val_t      res_q, out_q;

  seg_cmd_e      cmd;
  logic [31:0]   idx32, first32, last32, last_s;
  logic          accept, idx_ok, empty, inject, out_free;

  assign cmd     = seg_cmd_e'(s_axis_tuser);
  assign idx32   = 32'(s_axis_tdata[9:0]);
  assign first32 = 32'(s_axis_tdata[83:74]);
  assign last32  = 32'(s_axis_tdata[93:84]);
  assign last_s  = (last32 >= LEAVES) ? (LEAVES - 1) : last32;
  assign idx_ok  = idx32 < LEAVES;
  assign empty   = (first32 >= LEAVES) || (first32 > last_s);

  assign s_axis_tready = !clr_q && !busy_q;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign inject        = accept && ((cmd == CMD_QUERY) ||
                                    (((cmd == CMD_ADD) || (cmd == CMD_SET)) && idx_ok));
  assign out_free      = !out_vld_q || m_axis_tready;

  always_comb begin
    vld[0] = inject;
    ctl[0].is_query = (cmd == CMD_QUERY);
    ctl[0].is_add   = (cmd == CMD_ADD);
    ctl[0].live     = (cmd == CMD_QUERY) ? !empty : 1'b1;
    lo[0]  = (cmd == CMD_QUERY) ? IW'(first32) : IW'(idx32);
    hi[0]  = IW'(last_s);
    acc[0] = (cmd == CMD_QUERY) ? '0 : s_axis_tdata[73:10];
  end

  for (genvar g = 0; g <= LOG; g++) begin : g_lvl
    seg_cell #(
      .LVL (LOG - g),
      .IW  (IW)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .clr_i      (clr_q),
      .clr_addr_i (clr_cnt_q),
      .vld_i      (vld[g]),
      .ctl_i      (ctl[g]),
      .lo_i       (lo[g]),
      .hi_i       (hi[g]),
      .acc_i      (acc[g]),
      .vld_o      (vld[g+1]),
      .ctl_o      (ctl[g+1]),
      .lo_o       (lo[g+1]),
      .hi_o       (hi[g+1]),
      .acc_o      (acc[g+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_cnt_q  <= '0;
      busy_q     <= 1'b0;
      res_pend_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (clr_q) begin
        clr_cnt_q <= clr_cnt_q + IW'(1);
        if (clr_cnt_q == IW'(LEAVES - 1)) begin
          clr_q <= 1'b0;
        end
      end
      if (inject) begin
        busy_q <= 1'b1;
      end
      if (vld[LOG+1]) begin
        if (ctl[LOG+1].is_query) begin
          res_pend_q <= 1'b1;
        end else begin
          busy_q <= 1'b0;
        end
      end
      if (res_pend_q && out_free) begin
        res_pend_q <= 1'b0;
        busy_q     <= 1'b0;
        out_vld_q  <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld[LOG+1] && ctl[LOG+1].is_query) begin
      res_q <= acc[LOG+1];
    end
    if (res_pend_q && out_free) begin
      out_q <= res_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  `SEG_ASSERT_IMP(a_no_accept_clr, clr_q, !s_axis_tready, "item accepted during zeroing pass")
  `SEG_ASSERT_IMP(a_chain_busy, vld[LOG+1], busy_q, "chain result without item in flight")
  `SEG_ASSERT_IMP(a_load_pend, $rose(out_vld_q), $past(res_pend_q), "output loaded without result")
  `SEG_ASSERT(a_one_pend, !(res_pend_q && vld[LOG+1]), "second result while one pending")

endmodule

// ===== rtl/core/seg_cell.sv =====
// One tree level: node store, leaf update and paired-boundary query step
module seg_cell #(
  parameter int unsigned LVL = 0,
  parameter int unsigned IW  = 11
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clr_i,
  input  logic [IW-1:0]    clr_addr_i,
  input  logic             vld_i,
  input  seg_pkg::seg_ctl_t ctl_i,
  input  logic [IW-1:0]    lo_i,
  input  logic [IW-1:0]    hi_i,
  input  seg_pkg::seg_val_t acc_i,
  output logic             vld_o,
  output seg_pkg::seg_ctl_t ctl_o,
  output logic [IW-1:0]    lo_o,
  output logic [IW-1:0]    hi_o,
  output seg_pkg::seg_val_t acc_o
);
  import seg_pkg::*;

  localparam int unsigned AW  = (LVL > 0) ? LVL : 1;
  localparam int unsigned DEP = 1 << AW;

  seg_val_t mem [DEP];

  logic          a_vld_q;
  seg_ctl_t      a_ctl_q;
  logic [IW-1:0] a_lo_q, a_hi_q;
  seg_val_t      a_acc_q, rd_a_q, rd_b_q;
  logic [AW-1:0] rb_addr;

  logic          odd_lo, even_hi, live_d;
  logic [IW-1:0] lo_d, hi_d;
  seg_val_t      add_a, add_b, q_acc, own, up_acc;
  seg_ctl_t      ctl_d;

  assign rb_addr = ctl_i.is_query ? hi_i[AW-1:0] : (lo_i[AW-1:0] ^ AW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else begin
      a_vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_i) begin
      a_ctl_q <= ctl_i;
      a_lo_q  <= lo_i;
      a_hi_q  <= hi_i;
      a_acc_q <= acc_i;
      rd_a_q  <= mem[lo_i[AW-1:0]];
      rd_b_q  <= mem[rb_addr];
    end
  end

  always_comb begin
    odd_lo  = (LVL == 0) || a_lo_q[0];
    even_hi = (LVL != 0) && !a_hi_q[0];
    add_a   = (a_ctl_q.live && odd_lo) ? rd_a_q : '0;
    add_b   = (a_ctl_q.live && even_hi) ? rd_b_q : '0;
    q_acc   = a_acc_q + add_a + add_b;
    lo_d    = a_lo_q + IW'(odd_lo);
    hi_d    = a_hi_q - IW'(even_hi);
    live_d  = a_ctl_q.live && (lo_d <= hi_d) && !(even_hi && (a_hi_q == '0));
    own     = a_ctl_q.is_add ? (rd_a_q + a_acc_q) : a_acc_q;
    up_acc  = own + rd_b_q;
    ctl_d.is_query = a_ctl_q.is_query;
    ctl_d.is_add   = 1'b0;
    ctl_d.live     = a_ctl_q.is_query ? live_d : 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (clr_i) begin
      mem[clr_addr_i[AW-1:0]] <= '0;
    end else if (a_vld_q && !a_ctl_q.is_query) begin
      mem[a_lo_q[AW-1:0]] <= own;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o <= 1'b0;
    end else begin
      vld_o <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_vld_q) begin
      ctl_o <= ctl_d;
      lo_o  <= a_ctl_q.is_query ? (lo_d >> 1) : (a_lo_q >> 1);
      hi_o  <= hi_d >> 1;
      acc_o <= a_ctl_q.is_query ? q_acc : up_acc;
    end
  end

endmodule
